/* rtl/wsd_pkg.sv */
// Package for the WebSocket frame deframer: parse phases, header constants
// and the result record shared by the parser and the top level.
// Depends on nothing.
package wsd_pkg;

    // Parse phases of one frame.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } wsd_phase_t;

    // Length code field and the two codes that select an extended length.
    localparam logic [7:0] LEN_MASK   = 8'h7f;
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    // Header sizes in bytes.
    localparam logic [3:0] BASE_HDR_BYTES = 4'd2;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] KEY_BYTES      = 4'd4;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // One result item.
    typedef struct packed {
        logic        result_kind;
        logic        fin_bit;
        logic [2:0]  reserved_bits;
        logic [3:0]  opcode_value;
        logic        masked_frame;
        logic [63:0] payload_size;
        logic [3:0]  header_size;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } wsd_result_t;

endpackage

/* rtl/wsd_parser.sv */
// Frame parser state machine: header fields, extended length, masking key
// and payload byte counting. Builds a result for each payload byte and for the byte that completes a header.
// Depends on wsd_pkg.
module wsd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           stream_byte,
    output logic                 res_valid,
    output wsd_pkg::wsd_result_t res
);
    import wsd_pkg::*;

    wsd_phase_t  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  first_reg, first_next;
    logic        mask_reg, mask_next;
    logic [6:0]  code_reg, code_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kidx_reg, kidx_next;

    logic [3:0]  ext_cur;
    logic [3:0]  hsize_cur;
    logic [3:0]  ext_n;
    logic [3:0]  hsize_n;
    logic [63:0] len_n;
    logic        finish;
    logic        len_zero;
    logic        remain_last;
    logic [7:0]  key_byte;

    // Header size of the frame in progress, from the stored header fields.
    always_comb
    begin
        if (code_reg == LEN_CODE16)
        begin
            ext_cur = EXT16_BYTES;
        end
        else if (code_reg == LEN_CODE64)
        begin
            ext_cur = EXT64_BYTES;
        end
        else
        begin
            ext_cur = 4'd0;
        end
        hsize_cur = BASE_HDR_BYTES + ext_cur + (mask_reg ? KEY_BYTES : 4'd0);
    end

    // Key byte for the current payload byte; the first key byte is the MSB.
    always_comb
    begin
        unique case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign remain_last = (remain_reg <= 64'd1);

    // Next-state logic.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        mask_next   = mask_reg;
        code_next   = code_reg;
        acc_next    = acc_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        finish      = 1'b0;
        unique case (phase_reg)
            PH_SECOND:
            begin
                mask_next  = stream_byte[7];
                code_next  = stream_byte[6:0] & LEN_MASK[6:0];
                acc_next   = 64'd0;
                key_next   = 32'd0;
                count_next = BASE_HDR_BYTES;
                if (code_next == LEN_CODE16 || code_next == LEN_CODE64)
                begin
                    phase_next = PH_EXTLEN;
                end
                else if (stream_byte[7])
                begin
                    phase_next = PH_KEY;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                acc_next   = {acc_reg[55:0], stream_byte};
                count_next = count_reg + 4'd1;
                if (count_next >= BASE_HDR_BYTES + ext_cur)
                begin
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next   = {key_reg[23:0], stream_byte};
                count_next = count_reg + 4'd1;
                if (count_next >= hsize_cur)
                begin
                    finish = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                kidx_next = kidx_reg + 2'd1;
                if (remain_last)
                begin
                    remain_next = 64'd0;
                    phase_next  = PH_FIRST;
                end
                else
                begin
                    remain_next = remain_reg - 64'd1;
                end
            end
            default:
            begin
                first_next = stream_byte;
                count_next = 4'd1;
                phase_next = PH_SECOND;
            end
        endcase
        // Header size and decoded length, from the updated header fields.
        if (code_next == LEN_CODE16)
        begin
            ext_n = EXT16_BYTES;
        end
        else if (code_next == LEN_CODE64)
        begin
            ext_n = EXT64_BYTES;
        end
        else
        begin
            ext_n = 4'd0;
        end
        hsize_n  = BASE_HDR_BYTES + ext_n + (mask_next ? KEY_BYTES : 4'd0);
        len_n    = (ext_n != 4'd0) ? acc_next : {57'd0, code_next};
        len_zero = (len_n == 64'd0);
        // A completed header loads the payload counter.
        if (finish)
        begin
            remain_next = len_n;
            kidx_next   = 2'd0;
            phase_next  = len_zero ? PH_FIRST : PH_PAYLOAD;
        end
    end

    // Result for the byte at hand.
    always_comb
    begin
        res_valid         = finish || (phase_reg == PH_PAYLOAD);
        res.fin_bit       = first_next[7];
        res.reserved_bits = first_next[6:4];
        res.opcode_value  = first_next[3:0];
        res.masked_frame  = mask_next;
        res.payload_size  = len_n;
        res.header_size   = hsize_n;
        if (phase_reg == PH_PAYLOAD)
        begin
            res.result_kind   = KIND_DATA;
            res.payload_byte  = stream_byte ^ (mask_reg ? key_byte : 8'd0);
            res.last_of_frame = remain_last;
        end
        else
        begin
            res.result_kind   = KIND_HEADER;
            res.payload_byte  = 8'd0;
            res.last_of_frame = len_zero;
        end
    end

    // State registers, updated on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            count_reg  <= 4'd0;
            first_reg  <= 8'd0;
            mask_reg   <= 1'b0;
            code_reg   <= 7'd0;
            acc_reg    <= 64'd0;
            key_reg    <= 32'd0;
            remain_reg <= 64'd0;
            kidx_reg   <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            mask_reg   <= mask_next;
            code_reg   <= code_next;
            acc_reg    <= acc_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

/* rtl/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: input handshake, parser and
// the registered result stage. Depends on wsd_pkg and wsd_parser.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   stream_byte
//   output   out        out_valid / out_ready result fields, one port each
//
// One byte is accepted per cycle while in_ready is high; its result, if any,
// appears in the next cycle in the single result register behind the parser
// state. in_ready is high whenever the output register is empty or is being
// drained, so a stall on the output side holds the input only while a result
// is waiting. Reset clears the parser state and empties the output register.
module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic        fin_bit,
    output logic [2:0]  reserved_bits,
    output logic [3:0]  opcode_value,
    output logic        masked_frame,
    output logic [63:0] payload_size,
    output logic [3:0]  header_size,
    output logic [7:0]  payload_byte,
    output logic        last_of_frame
);
    import wsd_pkg::*;

    logic        accept;
    logic        res_valid;
    wsd_result_t res;
    wsd_result_t out_reg;
    logic        out_valid_reg, out_valid_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            out_valid_next = accept && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded when a transaction produces a result.
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.result_kind;
    assign fin_bit       = out_reg.fin_bit;
    assign reserved_bits = out_reg.reserved_bits;
    assign opcode_value  = out_reg.opcode_value;
    assign masked_frame  = out_reg.masked_frame;
    assign payload_size  = out_reg.payload_size;
    assign header_size   = out_reg.header_size;
    assign payload_byte  = out_reg.payload_byte;
    assign last_of_frame = out_reg.last_of_frame;

endmodule

/* tb/tb_websocket_frame_deframer.sv */
// Self-checking testbench for the WebSocket frame deframer. It builds frame byte
// streams, predicts every header and payload result, and checks the outputs.
// Depends on wsd_pkg and websocket_frame_deframer.
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 150;
    localparam int RANDOM_BYTES  = 900;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REPORT_LIMIT  = 10;

    // One stream byte waiting for the driver, with its idle gap in front.
    typedef struct {
        logic [7:0]  value;
        int unsigned idle_before;
    } stream_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    wire         out_ready;
    logic        result_kind;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  opcode_value;
    logic        masked_frame;
    logic [63:0] payload_size;
    logic [3:0]  header_size;
    logic [7:0]  payload_byte;
    logic        last_of_frame;

    logic        rx_ready = 1'b1;
    logic        hold_active = 1'b0;

    stream_item_t pending_bytes[$];
    wsd_result_t  expected_results[$];

    // Predictor state of the frame parser.
    wsd_phase_t  parse_state = PH_FIRST;
    logic [3:0]  hdr_bytes = '0;
    logic [7:0]  lead_byte = '0;
    logic        mask_seen = 1'b0;
    logic [6:0]  size_code = '0;
    logic [63:0] ext_length = '0;
    logic [31:0] key_word = '0;
    logic [63:0] bytes_left = '0;
    logic [1:0]  key_idx = '0;

    int unsigned idle_count = 0;
    int unsigned stall_left = 0;
    int unsigned calm_results = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int          checked_count = 0;
    int          mismatch_count = 0;
    int          bytes_accepted = 0;
    int          frames_queued = 0;
    int          headers_seen = 0;
    int          input_stall_cycles = 0;
    int          cycle_count = 0;

    assign out_ready = rx_ready && !hold_active;

    websocket_frame_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .fin_bit       (fin_bit),
        .reserved_bits (reserved_bits),
        .opcode_value  (opcode_value),
        .masked_frame  (masked_frame),
        .payload_size  (payload_size),
        .header_size   (header_size),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame)
    );

    // Free-running clock, period 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Number of extended length bytes selected by the length code.
    function automatic logic [3:0] ext_len_bytes();
        if (size_code == LEN_CODE16)
            return EXT16_BYTES;
        if (size_code == LEN_CODE64)
            return EXT64_BYTES;
        return 4'd0;
    endfunction

    function automatic logic [3:0] hdr_total();
        return BASE_HDR_BYTES + ext_len_bytes() + (mask_seen ? KEY_BYTES : 4'd0);
    endfunction

    function automatic logic [63:0] frame_length();
        return (ext_len_bytes() != 4'd0) ? ext_length : {57'd0, size_code};
    endfunction

    // Header fields that every result of the current frame carries.
    function automatic wsd_result_t frame_fields(input logic kind);
        wsd_result_t r;
        r.result_kind   = kind;
        r.fin_bit       = lead_byte[7];
        r.reserved_bits = lead_byte[6:4];
        r.opcode_value  = lead_byte[3:0];
        r.masked_frame  = mask_seen;
        r.payload_size  = frame_length();
        r.header_size   = hdr_total();
        r.payload_byte  = 8'h00;
        r.last_of_frame = 1'b0;
        return r;
    endfunction

    // The header is complete: emit its descriptor and set up the payload count.
    task automatic close_header();
        wsd_result_t r;
        logic [63:0] len;
        len = frame_length();
        r = frame_fields(KIND_HEADER);
        r.last_of_frame = (len == 64'd0);
        bytes_left = len;
        key_idx = 2'd0;
        parse_state = (len == 64'd0) ? PH_FIRST : PH_PAYLOAD;
        expected_results.push_back(r);
    endtask

    // Advance the predicted parser by one accepted stream byte.
    task automatic advance_parser(input logic [7:0] b);
        wsd_result_t r;
        logic [7:0]  k;
        case (parse_state)
            PH_SECOND:
            begin
                mask_seen = b[7];
                size_code = b[6:0];
                ext_length = '0;
                key_word = '0;
                hdr_bytes = BASE_HDR_BYTES;
                if (ext_len_bytes() != 4'd0)
                    parse_state = PH_EXTLEN;
                else if (mask_seen)
                    parse_state = PH_KEY;
                else
                    close_header();
            end
            PH_EXTLEN:
            begin
                ext_length = {ext_length[55:0], b};
                hdr_bytes = hdr_bytes + 4'd1;
                if (hdr_bytes >= BASE_HDR_BYTES + ext_len_bytes())
                begin
                    if (mask_seen)
                        parse_state = PH_KEY;
                    else
                        close_header();
                end
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                hdr_bytes = hdr_bytes + 4'd1;
                if (hdr_bytes >= hdr_total())
                    close_header();
            end
            PH_PAYLOAD:
            begin
                // Key bytes are applied in order, the first key byte first.
                k = mask_seen ? 8'(key_word >> (8 * (3 - key_idx))) : 8'h00;
                r = frame_fields(KIND_DATA);
                r.payload_byte = b ^ k;
                r.last_of_frame = (bytes_left <= 64'd1);
                key_idx = key_idx + 2'd1;
                if (bytes_left <= 64'd1)
                begin
                    bytes_left = '0;
                    parse_state = PH_FIRST;
                end
                else
                    bytes_left = bytes_left - 64'd1;
                expected_results.push_back(r);
            end
            default:
            begin
                lead_byte = b;
                hdr_bytes = 4'd1;
                parse_state = PH_SECOND;
            end
        endcase
    endtask

    // Queue one stream byte; quiet bytes follow their predecessor with no gap.
    task automatic push_stream_byte(input logic [7:0] value, input bit quiet);
        stream_item_t item;
        item.value = value;
        item.idle_before = quiet ? 0 : $urandom_range(0, 19);
        pending_bytes.push_back(item);
    endtask

    // Queue a whole frame. For short codes the length equals the code.
    task automatic queue_frame(input logic [7:0] head0, input logic masked,
                               input logic [6:0] code, input logic [63:0] length,
                               input logic [31:0] key, input int unsigned send_count,
                               input bit quiet);
        push_stream_byte(head0, quiet);
        push_stream_byte({masked, code}, quiet);
        if (code == LEN_CODE16)
        begin
            for (int i = 1; i >= 0; i--)
                push_stream_byte(length[8 * i +: 8], quiet);
        end
        else if (code == LEN_CODE64)
        begin
            for (int i = 7; i >= 0; i--)
                push_stream_byte(length[8 * i +: 8], quiet);
        end
        if (masked)
        begin
            for (int i = 3; i >= 0; i--)
                push_stream_byte(key[8 * i +: 8], quiet);
        end
        for (int unsigned n = 0; n < send_count; n++)
            push_stream_byte(8'($urandom_range(0, 255)), quiet);
        frames_queued++;
    endtask

    function automatic string describe(input wsd_result_t r);
        return $sformatf({"kind=%0d fin=%0d rsv=%0d op=%0d mask=%0d size=%016h",
                          " hdr=%0d byte=%02h last=%0d"},
                         r.result_kind, r.fin_bit, r.reserved_bits, r.opcode_value,
                         r.masked_frame, r.payload_size, r.header_size, r.payload_byte,
                         r.last_of_frame);
    endfunction

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        wsd_result_t seen;
        wsd_result_t want;
        seen = {result_kind, fin_bit, reserved_bits, opcode_value, masked_frame,
                payload_size, header_size, payload_byte, last_of_frame};
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("Result %0d arrived with nothing expected: %s",
                         checked_count, describe(seen));
        end
        else
        begin
            want = expected_results.pop_front();
            if (seen !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("Result %0d expected %s", checked_count, describe(want));
                    $display("Result %0d actual   %s", checked_count, describe(seen));
                end
            end
        end
    endtask

    // Driver: offers queued bytes after their idle gaps and predicts on each transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            stream_byte <= 8'h00;
            idle_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_parser(stream_byte);
                bytes_accepted++;
            end
            if (in_valid && !in_ready)
                input_stall_cycles++;
            else if (pending_bytes.size() == 0)
                in_valid <= 1'b0;
            else if (idle_count < pending_bytes[0].idle_before)
            begin
                idle_count++;
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                stream_byte <= pending_bytes[0].value;
                pending_bytes.delete(0);
                idle_count = 0;
            end
        end
    end

    // Monitor: checks each result transaction and draws the next receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready <= 1'b1;
            checked_count <= 0;
            stall_left = 0;
            calm_results = 0;
        end
        else if (out_valid && out_ready)
        begin
            check_result();
            if (result_kind == KIND_HEADER)
                headers_seen++;
            checked_count <= checked_count + 1;
            // Now and then a run of results is taken back to back.
            if (calm_results == 0 && $urandom_range(0, 7) == 0)
                calm_results = $urandom_range(10, 40);
            if (calm_results != 0)
            begin
                calm_results--;
                stall_left = 0;
            end
            else
                stall_left = $urandom_range(0, 19);
            rx_ready <= (stall_left == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            if (stall_left == 0)
                rx_ready <= 1'b1;
        end
    end

    // One long receiver hold-off so the block fills and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (!hold_done && checked_count >= HOLD_AFTER)
        begin
            hold_active <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_active <= 1'b0;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        bit          quiet;
        logic [7:0]  head0;
        logic        masked;
        logic [6:0]  code;
        logic [63:0] length;
        int unsigned pick;

        // Empty unmasked frame: the header carries the last flag.
        queue_frame(8'h81, 1'b0, 7'd0, 64'd0, 32'h0, 0, 1'b0);
        // Masked short frame with every reserved bit set.
        queue_frame(8'h72, 1'b1, 7'd3, 64'd3, 32'hFF00A55A, 3, 1'b0);
        // Non-minimal 16-bit length of one byte.
        queue_frame(8'h8F, 1'b0, LEN_CODE16, 64'd1, 32'h0, 1, 1'b1);
        // Non-minimal 64-bit length of zero.
        queue_frame(8'h08, 1'b0, LEN_CODE64, 64'd0, 32'h0, 0, 1'b0);

        // Random well-formed frames, mostly short, some with extended lengths.
        while (pending_bytes.size() < RANDOM_BYTES)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            head0 = 8'($urandom_range(0, 255));
            masked = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                length = 64'($urandom_range(0, 12));
                code = length[6:0];
            end
            else if (pick < 7)
            begin
                length = 64'($urandom_range(13, 125));
                code = length[6:0];
            end
            else if (pick < 9)
            begin
                code = LEN_CODE16;
                length = 64'($urandom_range(0, 40));
            end
            else
            begin
                code = LEN_CODE64;
                length = 64'($urandom_range(0, 40));
            end
            queue_frame(head0, masked, code, length, $urandom(), 32'(length), quiet);
        end

        // A masked frame with the largest 64-bit length; only its start is sent.
        queue_frame({4'h8, 4'($urandom_range(0, 15))}, 1'b1, LEN_CODE64,
                    64'hFFFF_FFFF_FFFF_FFFF, $urandom(), 12, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d stream bytes in %0d frames; checked %0d results, %0d headers.",
                 bytes_accepted, frames_queued, checked_count, headers_seen);
        $display("Input was held back for %0d cycles; %0d mismatches found.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* websocket_frame_deframer.f */
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
